[rtl/min_syllable_segmenter_unit_assert.svh]
// Assertion macros used by the segmenter RTL
`ifndef MIN_SYLLABLE_SEGMENTER_UNIT_ASSERT_SVH
`define MIN_SYLLABLE_SEGMENTER_UNIT_ASSERT_SVH

// Check a consequence in the same cycle
`define MSS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the next cycle
`define MSS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mss_pkg.sv]
`default_nettype none
package mss_pkg;

   localparam int MAX_PIECE = 6;
   // entries in each half of the syllable table
   localparam int SYL_TAB_DEPTH = 252;

   typedef logic [47:0] syl_word_type;

   typedef struct packed {
      logic [2:0]   len;
      syl_word_type text;   // first character in the top byte
   } syl_entry_type;

   // First half of the syllable table
   function automatic syl_word_type syl_tab_a(input logic [7:0] idx);
      case (idx)
         8'd0: return "a";       8'd1: return "ai";      8'd2: return "an";
         8'd3: return "ang";     8'd4: return "ao";      8'd5: return "ba";
         8'd6: return "bai";     8'd7: return "ban";     8'd8: return "bang";
         8'd9: return "bao";     8'd10: return "bei";    8'd11: return "ben";
         8'd12: return "beng";   8'd13: return "bi";     8'd14: return "bian";
         8'd15: return "biang";  8'd16: return "biao";   8'd17: return "bie";
         8'd18: return "bin";    8'd19: return "bing";   8'd20: return "bo";
         8'd21: return "bu";     8'd22: return "ca";     8'd23: return "cai";
         8'd24: return "can";    8'd25: return "cang";   8'd26: return "cao";
         8'd27: return "ce";     8'd28: return "cen";    8'd29: return "ceng";
         8'd30: return "cha";    8'd31: return "chai";   8'd32: return "chan";
         8'd33: return "chang";  8'd34: return "chao";   8'd35: return "che";
         8'd36: return "chen";   8'd37: return "cheng";  8'd38: return "chi";
         8'd39: return "chong";  8'd40: return "chou";   8'd41: return "chu";
         8'd42: return "chua";   8'd43: return "chuai";  8'd44: return "chuan";
         8'd45: return "chuang"; 8'd46: return "chui";   8'd47: return "chun";
         8'd48: return "chuo";   8'd49: return "ci";     8'd50: return "cong";
         8'd51: return "cou";    8'd52: return "cu";     8'd53: return "cuan";
         8'd54: return "cui";    8'd55: return "cun";    8'd56: return "cuo";
         8'd57: return "da";     8'd58: return "dai";    8'd59: return "dan";
         8'd60: return "dang";   8'd61: return "dao";    8'd62: return "de";
         8'd63: return "dei";    8'd64: return "den";    8'd65: return "deng";
         8'd66: return "di";     8'd67: return "dia";    8'd68: return "dian";
         8'd69: return "diao";   8'd70: return "die";    8'd71: return "ding";
         8'd72: return "diu";    8'd73: return "dong";   8'd74: return "dou";
         8'd75: return "du";     8'd76: return "duan";   8'd77: return "dui";
         8'd78: return "dun";    8'd79: return "duo";    8'd80: return "e";
         8'd81: return "ei";     8'd82: return "en";     8'd83: return "er";
         8'd84: return "fa";     8'd85: return "fan";    8'd86: return "fang";
         8'd87: return "fei";    8'd88: return "fen";    8'd89: return "feng";
         8'd90: return "fiao";   8'd91: return "fo";     8'd92: return "fou";
         8'd93: return "fu";     8'd94: return "ga";     8'd95: return "gai";
         8'd96: return "gan";    8'd97: return "gang";   8'd98: return "gao";
         8'd99: return "ge";     8'd100: return "gei";   8'd101: return "gen";
         8'd102: return "geng";  8'd103: return "gong";  8'd104: return "gou";
         8'd105: return "gu";    8'd106: return "gua";   8'd107: return "guai";
         8'd108: return "guan";  8'd109: return "guang"; 8'd110: return "gui";
         8'd111: return "gun";   8'd112: return "guo";   8'd113: return "ha";
         8'd114: return "hai";   8'd115: return "han";   8'd116: return "hang";
         8'd117: return "hao";   8'd118: return "he";    8'd119: return "hei";
         8'd120: return "hen";   8'd121: return "heng";  8'd122: return "hong";
         8'd123: return "hou";   8'd124: return "hu";    8'd125: return "hua";
         8'd126: return "huai";  8'd127: return "huan";  8'd128: return "huang";
         8'd129: return "hui";   8'd130: return "hun";   8'd131: return "huo";
         8'd132: return "ji";    8'd133: return "jia";   8'd134: return "jian";
         8'd135: return "jiang"; 8'd136: return "jiao";  8'd137: return "jie";
         8'd138: return "jin";   8'd139: return "jing";  8'd140: return "jiong";
         8'd141: return "jiu";   8'd142: return "ju";    8'd143: return "juan";
         8'd144: return "jue";   8'd145: return "jun";   8'd146: return "jve";
         8'd147: return "ka";    8'd148: return "kai";   8'd149: return "kan";
         8'd150: return "kang";  8'd151: return "kao";   8'd152: return "ke";
         8'd153: return "kei";   8'd154: return "ken";   8'd155: return "keng";
         8'd156: return "kong";  8'd157: return "kou";   8'd158: return "ku";
         8'd159: return "kua";   8'd160: return "kuai";  8'd161: return "kuan";
         8'd162: return "kuang"; 8'd163: return "kui";   8'd164: return "kun";
         8'd165: return "kuo";   8'd166: return "la";    8'd167: return "lai";
         8'd168: return "lan";   8'd169: return "lang";  8'd170: return "lao";
         8'd171: return "le";    8'd172: return "lei";   8'd173: return "leng";
         8'd174: return "li";    8'd175: return "lia";   8'd176: return "lian";
         8'd177: return "liang"; 8'd178: return "liao";  8'd179: return "lie";
         8'd180: return "lin";   8'd181: return "ling";  8'd182: return "liu";
         8'd183: return "lo";    8'd184: return "long";  8'd185: return "lou";
         8'd186: return "lu";    8'd187: return "luan";  8'd188: return "lue";
         8'd189: return "lun";   8'd190: return "luo";   8'd191: return "lv";
         8'd192: return "lve";   8'd193: return "ma";    8'd194: return "mai";
         8'd195: return "man";   8'd196: return "mang";  8'd197: return "mao";
         8'd198: return "me";    8'd199: return "mei";   8'd200: return "men";
         8'd201: return "meng";  8'd202: return "mi";    8'd203: return "mian";
         8'd204: return "miao";  8'd205: return "mie";   8'd206: return "min";
         8'd207: return "ming";  8'd208: return "miu";   8'd209: return "mo";
         8'd210: return "mou";   8'd211: return "mu";    8'd212: return "na";
         8'd213: return "nai";   8'd214: return "nan";   8'd215: return "nang";
         8'd216: return "nao";   8'd217: return "ne";    8'd218: return "nei";
         8'd219: return "nen";   8'd220: return "neng";  8'd221: return "ni";
         8'd222: return "nian";  8'd223: return "niang"; 8'd224: return "niao";
         8'd225: return "nie";   8'd226: return "nin";   8'd227: return "ning";
         8'd228: return "niu";   8'd229: return "nong";  8'd230: return "nou";
         8'd231: return "nu";    8'd232: return "nuan";  8'd233: return "nue";
         8'd234: return "nun";   8'd235: return "nuo";   8'd236: return "nv";
         8'd237: return "nve";   8'd238: return "o";     8'd239: return "ou";
         8'd240: return "pa";    8'd241: return "pai";   8'd242: return "pan";
         8'd243: return "pang";  8'd244: return "pao";   8'd245: return "pei";
         8'd246: return "pen";   8'd247: return "peng";  8'd248: return "pi";
         8'd249: return "pian";  8'd250: return "piao";  8'd251: return "pie";
         default: return '0;
      endcase
   endfunction

   // Second half of the syllable table; unused slots read as empty
   function automatic syl_word_type syl_tab_b(input logic [7:0] idx);
      case (idx)
         8'd0: return "pin";     8'd1: return "ping";    8'd2: return "po";
         8'd3: return "pou";     8'd4: return "pu";      8'd5: return "qi";
         8'd6: return "qia";     8'd7: return "qian";    8'd8: return "qiang";
         8'd9: return "qiao";    8'd10: return "qie";    8'd11: return "qin";
         8'd12: return "qing";   8'd13: return "qiong";  8'd14: return "qiu";
         8'd15: return "qu";     8'd16: return "quan";   8'd17: return "que";
         8'd18: return "qun";    8'd19: return "qve";    8'd20: return "ran";
         8'd21: return "rang";   8'd22: return "rao";    8'd23: return "re";
         8'd24: return "ren";    8'd25: return "reng";   8'd26: return "ri";
         8'd27: return "rong";   8'd28: return "rou";    8'd29: return "ru";
         8'd30: return "ruan";   8'd31: return "rui";    8'd32: return "run";
         8'd33: return "ruo";    8'd34: return "sa";     8'd35: return "sai";
         8'd36: return "san";    8'd37: return "sang";   8'd38: return "sao";
         8'd39: return "se";     8'd40: return "sen";    8'd41: return "seng";
         8'd42: return "sha";    8'd43: return "shai";   8'd44: return "shan";
         8'd45: return "shang";  8'd46: return "shao";   8'd47: return "she";
         8'd48: return "shei";   8'd49: return "shen";   8'd50: return "sheng";
         8'd51: return "shi";    8'd52: return "shou";   8'd53: return "shu";
         8'd54: return "shua";   8'd55: return "shuai";  8'd56: return "shuan";
         8'd57: return "shuang"; 8'd58: return "shui";   8'd59: return "shun";
         8'd60: return "shuo";   8'd61: return "si";     8'd62: return "song";
         8'd63: return "sou";    8'd64: return "su";     8'd65: return "suan";
         8'd66: return "sui";    8'd67: return "sun";    8'd68: return "suo";
         8'd69: return "ta";     8'd70: return "tai";    8'd71: return "tan";
         8'd72: return "tang";   8'd73: return "tao";    8'd74: return "te";
         8'd75: return "teng";   8'd76: return "ti";     8'd77: return "tian";
         8'd78: return "tiao";   8'd79: return "tie";    8'd80: return "ting";
         8'd81: return "tong";   8'd82: return "tou";    8'd83: return "tu";
         8'd84: return "tuan";   8'd85: return "tui";    8'd86: return "tun";
         8'd87: return "tuo";    8'd88: return "wa";     8'd89: return "wai";
         8'd90: return "wan";    8'd91: return "wang";   8'd92: return "wei";
         8'd93: return "wen";    8'd94: return "weng";   8'd95: return "wo";
         8'd96: return "wu";     8'd97: return "xi";     8'd98: return "xia";
         8'd99: return "xian";   8'd100: return "xiang"; 8'd101: return "xiao";
         8'd102: return "xie";   8'd103: return "xin";   8'd104: return "xing";
         8'd105: return "xiong"; 8'd106: return "xiu";   8'd107: return "xu";
         8'd108: return "xuan";  8'd109: return "xue";   8'd110: return "xun";
         8'd111: return "xve";   8'd112: return "ya";    8'd113: return "yan";
         8'd114: return "yang";  8'd115: return "yao";   8'd116: return "ye";
         8'd117: return "yi";    8'd118: return "yin";   8'd119: return "ying";
         8'd120: return "yo";    8'd121: return "yong";  8'd122: return "you";
         8'd123: return "yu";    8'd124: return "yuan";  8'd125: return "yue";
         8'd126: return "yun";   8'd127: return "yve";   8'd128: return "za";
         8'd129: return "zai";   8'd130: return "zan";   8'd131: return "zang";
         8'd132: return "zao";   8'd133: return "ze";    8'd134: return "zei";
         8'd135: return "zen";   8'd136: return "zeng";  8'd137: return "zha";
         8'd138: return "zhai";  8'd139: return "zhan";  8'd140: return "zhang";
         8'd141: return "zhao";  8'd142: return "zhe";   8'd143: return "zhei";
         8'd144: return "zhen";  8'd145: return "zheng"; 8'd146: return "zhi";
         8'd147: return "zhong"; 8'd148: return "zhou";  8'd149: return "zhu";
         8'd150: return "zhua";  8'd151: return "zhuai"; 8'd152: return "zhuan";
         8'd153: return "zhuang"; 8'd154: return "zhui"; 8'd155: return "zhun";
         8'd156: return "zhuo";  8'd157: return "zi";    8'd158: return "zong";
         8'd159: return "zou";   8'd160: return "zu";    8'd161: return "zuan";
         8'd162: return "zui";   8'd163: return "zun";   8'd164: return "zuo";
         default: return '0;
      endcase
   endfunction

   // Count the characters and move the first one to the top byte
   function automatic syl_entry_type syl_norm(input syl_word_type raw);
      logic [2:0]    n;
      syl_entry_type r;
      n = '0;
      for (int i = 0; i < MAX_PIECE; i++) begin
         if (raw[8*i +: 8] != 8'd0) n = n + 3'd1;
      end
      r.len  = n;
      r.text = raw << (8 * (MAX_PIECE - int'(n)));
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/mss_ram.sv]
`default_nettype none
module mss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/min_syllable_segmenter_unit.sv]
// Loading: one request byte per cycle, req_stall low while loading.
// Segmentation: for each buffered character, last to first, a read, a shift, a
// syllable table scan (two table entries compared per cycle) and a decide step.
// Output: per piece, a first-length read, then a response that rsp_stall holds.
// Reset: synchronous, active high; clears sequencer, count, overflow flag and
// the prefix register; buffers are not cleared.
`default_nettype none
`include "min_syllable_segmenter_unit_assert.svh"
module min_syllable_segmenter_unit #(
   parameter int MAX_LEN = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_char_valid,
   input  wire logic [7:0] req_character,
   input  wire logic       req_end_of_string,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_found,
   output logic            rsp_overflow,
   output logic [5:0]      rsp_piece_start,
   output logic [2:0]      rsp_piece_length,
   output logic            rsp_last_piece,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_accept_prefixes
);
   import mss_pkg::*;

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   localparam logic [2:0] S_LOAD   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_SHIFT  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_EREAD  = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;
   localparam logic [2:0] S_NF     = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic          prefix_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          ov_ff, ov_in;
   logic          nf_ov_ff, nf_ov_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] p_ff, p_in;
   logic [7:0]    idx_ff, idx_in;
   logic          ent_vld_ff, ent_vld_in;
   syl_entry_type ent_a_ff, ent_b_ff;
   logic [7:0]    win_ff [MAX_PIECE];
   logic [MAX_PIECE-1:0] ok_ff, ok_in;
   logic [MAX_PIECE-1:0] reach_ff;
   logic [CW-1:0] cnt_ff [MAX_PIECE];

   logic          req_acc;
   logic          buf_wr;
   logic [7:0]    buf_rdata;
   logic          fl_wr;
   logic [2:0]    fl_rdata;
   logic [MAX_PIECE-1:0] hit;
   logic [CW-1:0] best_c;
   logic [2:0]    best_l;
   logic [CW-1:0] rem;
   logic          is_last;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_LOAD);
   assign csr_ready = 1'b1;
   assign buf_wr    = req_acc && req_char_valid && (count_ff < CW'(MAX_LEN));
   assign fl_wr     = (state_ff == S_DECIDE);

   mss_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_char_buf (
      .clock   (clock),
      .wr_en   (buf_wr),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_character),
      .rd_en   (state_ff == S_READ),
      .rd_addr (AW'(p_ff - CW'(1))),
      .rd_data (buf_rdata)
   );

   mss_ram #(.WIDTH(3), .DEPTH(MAX_LEN)) u_first_len (
      .clock   (clock),
      .wr_en   (fl_wr),
      .wr_addr (p_ff[AW-1:0]),
      .wr_data (best_l),
      .rd_en   (state_ff == S_EREAD),
      .rd_addr (p_ff[AW-1:0]),
      .rd_data (fl_rdata)
   );

   // Compare both fetched table entries against the window
   always_comb begin
      logic pre_a, pre_b;
      hit   = '0;
      pre_a = 1'b1;
      pre_b = 1'b1;
      for (int l = 1; l <= MAX_PIECE; l++) begin
         pre_a = pre_a && (ent_a_ff.text[47-8*(l-1) -: 8] == win_ff[l-1]);
         pre_b = pre_b && (ent_b_ff.text[47-8*(l-1) -: 8] == win_ff[l-1]);
         hit[l-1] = (pre_a && (prefix_ff ? (ent_a_ff.len >= 3'(l)) : (ent_a_ff.len == 3'(l))))
                 || (pre_b && (prefix_ff ? (ent_b_ff.len >= 3'(l)) : (ent_b_ff.len == 3'(l))));
      end
   end

   // Pick the least piece count, shorter first piece on a tie
   always_comb begin
      logic [CW-1:0] c;
      rem    = n_ff - p_ff;
      best_c = '0;
      best_l = '0;
      for (int k = 0; k < MAX_PIECE; k++) begin
         c = cnt_ff[k] + CW'(1);
         if (ok_ff[k] && reach_ff[k] && (CW'(k + 1) <= rem)
             && ((best_c == '0) || (c < best_c))) begin
            best_c = c;
            best_l = 3'(k + 1);
         end
      end
   end

   assign is_last = ({1'b0, p_ff} + (CW+1)'(fl_rdata)) >= {1'b0, n_ff};

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ov_in      = ov_ff;
      nf_ov_in   = nf_ov_ff;
      n_in       = n_ff;
      p_in       = p_ff;
      idx_in     = idx_ff;
      ent_vld_in = 1'b0;
      ok_in      = ok_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (req_char_valid) begin
                  if (count_ff < CW'(MAX_LEN)) count_in = count_ff + CW'(1);
                  else ov_in = 1'b1;
               end
               if (req_end_of_string) begin
                  count_in = '0;
                  ov_in    = 1'b0;
                  nf_ov_in = ov_ff || (req_char_valid && (count_ff == CW'(MAX_LEN)));
                  n_in     = count_in;
                  if (req_char_valid && (count_ff < CW'(MAX_LEN)))
                     n_in = count_ff + CW'(1);
                  else
                     n_in = count_ff;
                  p_in     = n_in;
                  if (nf_ov_in || (n_in == '0)) state_in = S_NF;
                  else state_in = S_READ;
               end
            end
         end
         S_READ: begin
            p_in     = p_ff - CW'(1);
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            idx_in   = '0;
            ok_in    = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (ent_vld_ff) ok_in = ok_ff | hit;
            if (idx_ff == 8'(SYL_TAB_DEPTH)) begin
               state_in = S_DECIDE;
            end else begin
               idx_in     = idx_ff + 8'd1;
               ent_vld_in = 1'b1;
            end
         end
         S_DECIDE: begin
            if (p_ff != '0) state_in = S_READ;
            else if (best_c != '0) state_in = S_EREAD;
            else begin
               nf_ov_in = 1'b0;
               state_in = S_NF;
            end
         end
         S_EREAD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (is_last) state_in = S_LOAD;
               else begin
                  p_in     = p_ff + CW'(fl_rdata);
                  state_in = S_EREAD;
               end
            end
         end
         S_NF: begin
            if (!rsp_stall) state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         ov_ff      <= 1'b0;
         ent_vld_ff <= 1'b0;
         prefix_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         ov_ff      <= ov_in;
         ent_vld_ff <= ent_vld_in;
         if (csr_valid && csr_ready) prefix_ff <= csr_accept_prefixes;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      nf_ov_ff <= nf_ov_in;
      n_ff     <= n_in;
      p_ff     <= p_in;
      idx_ff   <= idx_in;
      ok_ff    <= ok_in;
      ent_a_ff <= syl_norm(syl_tab_a(idx_ff));
      ent_b_ff <= syl_norm(syl_tab_b(idx_ff));
      // start a run with the end of the string as the only reachable stop
      if (state_ff == S_LOAD) begin
         reach_ff <= MAX_PIECE'(1);
         for (int k = 0; k < MAX_PIECE; k++) cnt_ff[k] <= '0;
      end
      // advance the window by one character towards the start
      if (state_ff == S_SHIFT) begin
         win_ff[0] <= buf_rdata;
         for (int k = 1; k < MAX_PIECE; k++) win_ff[k] <= win_ff[k-1];
      end
      // push this position's result in front of the later ones
      if (state_ff == S_DECIDE) begin
         reach_ff  <= {reach_ff[MAX_PIECE-2:0], (best_c != '0)};
         cnt_ff[0] <= best_c;
         for (int k = 1; k < MAX_PIECE; k++) cnt_ff[k] <= cnt_ff[k-1];
      end
   end

   // Response
   assign rsp_valid        = (state_ff == S_OUT) || (state_ff == S_NF);
   assign rsp_found        = (state_ff == S_OUT);
   assign rsp_overflow     = (state_ff == S_NF) && nf_ov_ff;
   assign rsp_piece_start  = (state_ff == S_OUT) ? 6'(p_ff) : 6'd0;
   assign rsp_piece_length = (state_ff == S_OUT) ? fl_rdata : 3'd0;
   assign rsp_last_piece   = (state_ff == S_OUT) ? is_last : 1'b1;

   `MSS_ASSERT_NOW(a_busy_while_rsp, rsp_valid, req_stall, "request taken during response")
   `MSS_ASSERT_NOW(a_piece_len, state_ff == S_OUT, fl_rdata != 3'd0, "empty piece emitted")
   `MSS_ASSERT_NEXT(a_sweep_step, (state_ff == S_DECIDE) && (p_ff != '0), state_ff == S_READ,
      "sweep did not step back")
   `MSS_ASSERT_NOW(a_ov_nf, rsp_overflow, !rsp_found && rsp_last_piece, "overflow on a piece")

endmodule
`default_nettype wire
